// ===== hdl/iba_pkg.sv =====
package iba_pkg;

	localparam int NumBlocksDef = 128;
	localparam int MaxFilesDef  = 64;

	localparam int OpW     = 2;
	localparam int KeyW    = 64;
	localparam int SizeW   = 8;
	localparam int StatusW = 3;
	localparam int CfgW    = 8;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_DELETE = 2'd1,
		OP_QBLOCK = 2'd2,
		OP_QENTRY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_INDEX  = 3'd1,
		ST_NO_SPACE  = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_DIR_FULL  = 3'd4
	} status_t;

endpackage

// ===== hdl/indexed_block_allocator_top.sv =====
// Channel  Dir  Fields (tdata low bit first)                                Handshake
// s_axis   in   tdata: opcode, file_key, file_size, block_number,           tvalid/tready
//               entry_position (88 bits)
// m_axis   out  tdata: status, idx_blk, file_size_out, entry_block,         tvalid/tready
//               occupied, file_count (33 bits, padded to 40)
// cfg      in   cfg_we, cfg_wdata: disk_blocks                              write strobe
//
// One request at a time; s_axis_tready is low from acceptance until the result is
// registered. Create runs a map scan, a data scan and, when space runs out, a rollback;
// delete runs a directory search, a row walk and compaction; query block state reads
// the map directly; query file entry runs a directory search and one row read. All run
// on one shared step sequencer touching one map bit, one row entry or one directory
// entry per cycle; each memory read spans a read phase and a use phase.
// Reset clears the free map, file count and control; stores are undefined until written.
// The result register holds while m_axis_tready is low; the next request may be
// accepted while it waits.
module indexed_block_allocator_top #(
	parameter int NUM_BLOCKS = iba_pkg::NumBlocksDef,
	parameter int MAX_FILES  = iba_pkg::MaxFilesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[1:0], file_key[65:2], file_size[73:66], block_number[80:74],
	// entry_position[87:81]
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], idx_blk[9:3], file_size_out[17:10], entry_block[24:18],
	// occupied[25], file_count[32:26], zero pad [39:33]
	output logic [39:0] m_axis_tdata
);
	import iba_pkg::*;

	localparam int BW  = $clog2(NUM_BLOCKS);
	localparam int FW  = $clog2(MAX_FILES + 1);
	localparam int DW  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int CW  = BW + 1;
	localparam int RW  = 2 * BW;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_IDX    = 10'b0000000010,
		S_DATA   = 10'b0000000100,
		S_ROLL   = 10'b0000001000,
		S_FIND   = 10'b0000010000,
		S_WALK   = 10'b0000100000,
		S_COMP   = 10'b0001000000,
		S_ENTRY  = 10'b0010000000,
		S_ERD    = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q;

	// request fields
	logic [1:0]       in_op;
	logic [63:0]      in_key;
	logic [7:0]       in_size;
	logic [6:0]       in_blk;
	logic [6:0]       in_pos;
	assign in_op   = s_axis_tdata[1:0];
	assign in_key  = s_axis_tdata[65:2];
	assign in_size = s_axis_tdata[73:66];
	assign in_blk  = s_axis_tdata[80:74];
	assign in_pos  = s_axis_tdata[87:81];

	logic [7:0]       disk_q;
	op_t              op_q;
	logic [63:0]      key_q;
	logic [8:0]       size_q;
	logic [6:0]       pos_q;
	logic [NUM_BLOCKS-1:0] map_q;
	logic [FW-1:0]    files_q;
	logic [CW-1:0]    i_q;      // block scan index
	logic [8:0]       j_q;      // row position
	logic [FW-1:0]    f_q;      // directory index
	logic [BW-1:0]    idx_q;
	logic [CW-1:0]    n_lim;

	// working result fields
	logic [2:0]       st_q;
	logic [6:0]       ob_idx_q;
	logic [7:0]       ob_size_q;
	logic [6:0]       ob_ent_q;
	logic             ob_occ_q;

	// output register
	logic             ovld_q;
	logic [32:0]      res_q;

	// memories
	logic [BW-1:0]    row_mem [NUM_BLOCKS*NUM_BLOCKS];
	logic [63:0]      dkey_mem [MAX_FILES];
	logic [7:0]       dsize_mem [MAX_FILES];
	logic [BW-1:0]    didx_mem [MAX_FILES];
	logic [BW-1:0]    row_rd_q;
	logic [63:0]      dkey_rd_q;
	logic [7:0]       dsize_rd_q;
	logic [BW-1:0]    didx_rd_q;

	// row memory ports
	logic             row_we;
	logic [RW-1:0]    row_wa, row_ra;
	logic [BW-1:0]    row_wd;
	// directory ports
	logic             dir_we;
	logic [DW-1:0]    dir_wa, dir_ra;
	logic [63:0]      dir_wkey;
	logic [7:0]       dir_wsize;
	logic [BW-1:0]    dir_widx;

	// ph_q: read phase toggle for registered memory reads
	logic             ph_q;

	assign n_lim = (disk_q > 8'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(disk_q);
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = {7'd0, res_q};

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wa] <= row_wd;
		end
		row_rd_q <= row_mem[row_ra];
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dkey_mem[dir_wa]  <= dir_wkey;
			dsize_mem[dir_wa] <= dir_wsize;
			didx_mem[dir_wa]  <= dir_widx;
		end
		dkey_rd_q  <= dkey_mem[dir_ra];
		dsize_rd_q <= dsize_mem[dir_ra];
		didx_rd_q  <= didx_mem[dir_ra];
	end

	// memory address and write control
	always_comb begin
		row_we   = 1'b0;
		row_wa   = {idx_q, j_q[BW-1:0]};
		row_wd   = i_q[BW-1:0];
		row_ra   = {idx_q, j_q[BW-1:0]};
		dir_we   = 1'b0;
		dir_wa   = f_q[DW-1:0];
		dir_wkey = key_q;
		dir_wsize = size_q[7:0];
		dir_widx = idx_q;
		dir_ra   = f_q[DW-1:0];
		unique case (state_q)
			S_DATA: begin
				row_we = (j_q < size_q) && (i_q < n_lim) && !map_q[i_q[BW-1:0]];
			end
			S_ROLL, S_WALK, S_ENTRY, S_ERD: begin
				row_ra = {idx_q, j_q[BW-1:0]};
			end
			S_COMP: begin
				// read next entry, write previous when phase set
				dir_ra    = DW'(f_q + FW'(1));
				dir_we    = ph_q;
				dir_wkey  = dkey_rd_q;
				dir_wsize = dsize_rd_q;
				dir_widx  = didx_rd_q;
			end
			default: begin
			end
		endcase
		if (state_q == S_DATA && j_q == size_q) begin
			dir_we = 1'b1;
			dir_wa = files_q[DW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			disk_q   <= 8'd128;
			map_q    <= '0;
			files_q  <= '0;
			ovld_q   <= 1'b0;
			res_q    <= '0;
			ph_q     <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			f_q      <= '0;
		end else begin
			if (cfg_we) begin
				disk_q <= cfg_wdata;
			end
			// output register: load on completion, drop when taken
			if (state_q == S_DONE && (!ovld_q || m_axis_tready)) begin
				ovld_q <= 1'b1;
				res_q  <= {7'(files_q), ob_occ_q, ob_ent_q, ob_size_q, ob_idx_q, st_q};
			end else if (ovld_q && m_axis_tready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						op_q      <= op_t'(in_op);
						key_q     <= in_key;
						size_q    <= {1'b0, in_size};
						pos_q     <= in_pos;
						st_q      <= ST_OK;
						ob_idx_q  <= '0;
						ob_size_q <= '0;
						ob_ent_q  <= '0;
						ob_occ_q  <= 1'b0;
						i_q       <= '0;
						j_q       <= '0;
						f_q       <= '0;
						ph_q      <= 1'b0;
						unique case (op_t'(in_op))
							OP_CREATE: begin
								if (files_q >= FW'(MAX_FILES)) begin
									st_q    <= ST_DIR_FULL;
									state_q <= S_DONE;
								end else begin
									state_q <= S_IDX;
								end
							end
							OP_QBLOCK: begin
								ob_occ_q <= (32'(in_blk) < NUM_BLOCKS) ?
									map_q[in_blk[BW-1:0]] : 1'b0;
								state_q  <= S_DONE;
							end
							OP_DELETE, OP_QENTRY: begin
								state_q <= S_FIND;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_IDX: begin
					// lowest free block becomes the index block
					if (i_q >= n_lim) begin
						st_q    <= ST_NO_INDEX;
						state_q <= S_DONE;
					end else if (!map_q[i_q[BW-1:0]]) begin
						idx_q <= i_q[BW-1:0];
						map_q[i_q[BW-1:0]] <= 1'b1;
						i_q   <= '0;
						state_q <= S_DATA;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_DATA: begin
					if (j_q == size_q) begin
						files_q   <= files_q + FW'(1);
						ob_idx_q  <= 7'(idx_q);
						ob_size_q <= size_q[7:0];
						state_q   <= S_DONE;
					end else if (i_q >= n_lim) begin
						st_q    <= ST_NO_SPACE;
						j_q     <= '0;
						i_q     <= CW'(j_q);
						ph_q    <= 1'b0;
						state_q <= S_ROLL;
					end else begin
						if (!map_q[i_q[BW-1:0]]) begin
							map_q[i_q[BW-1:0]] <= 1'b1;
							j_q <= j_q + 9'd1;
						end
						i_q <= i_q + CW'(1);
					end
				end
				S_ROLL: begin
					// i_q holds taken count; read then free each entry
					if (!ph_q) begin
						if (9'(i_q) == j_q) begin
							map_q[idx_q] <= 1'b0;
							state_q <= S_DONE;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						map_q[row_rd_q] <= 1'b0;
						j_q  <= j_q + 9'd1;
						ph_q <= 1'b0;
					end
				end
				S_FIND: begin
					// one directory read per entry: address in the first phase, compare in the second
					if (!ph_q) begin
						if (f_q >= files_q) begin
							st_q    <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if (dkey_rd_q == key_q) begin
							idx_q     <= didx_rd_q;
							size_q    <= {1'b0, dsize_rd_q};
							ob_idx_q  <= 7'(didx_rd_q);
							ob_size_q <= dsize_rd_q;
							j_q       <= '0;
							if (op_q == OP_QENTRY) begin
								state_q <= S_ENTRY;
							end else begin
								state_q <= S_WALK;
							end
						end else begin
							f_q <= f_q + FW'(1);
						end
					end
				end
				S_WALK: begin
					if (!ph_q) begin
						if (j_q >= size_q || j_q >= 9'(NUM_BLOCKS)) begin
							map_q[idx_q] <= 1'b0;
							state_q <= S_COMP;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						map_q[row_rd_q] <= 1'b0;
						j_q  <= j_q + 9'd1;
						ph_q <= 1'b0;
					end
				end
				S_COMP: begin
					// shift entries down: read f+1, then write at f
					if (!ph_q) begin
						if (f_q + FW'(1) >= files_q) begin
							files_q <= files_q - FW'(1);
							state_q <= S_DONE;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						f_q  <= f_q + FW'(1);
						ph_q <= 1'b0;
					end
				end
				S_ENTRY: begin
					if (9'(pos_q) < size_q) begin
						j_q     <= 9'(pos_q);
						state_q <= S_ERD;
					end else begin
						st_q    <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end
				end
				S_ERD: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ob_ent_q <= 7'(row_rd_q);
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!ovld_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		files_q <= FW'(MAX_FILES))
		else $error("file count beyond directory size");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_axis_tready)
		else $error("ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while held");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP && !ph_q && (f_q + FW'(1) >= files_q)) |=>
		(files_q == $past(files_q) - FW'(1)))
		else $error("delete did not drop file count");

endmodule
